@@ sv/pbrd_pkg.sv @@
// Package for the pulse beat rate detector: register indexes, reset values,
// result layout, sequencer states and history commands. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pbrd_pkg;

    localparam int HISTORY_DEPTH_DEF = 10;
    localparam int SAMPLE_BITS_DEF   = 10;
    localparam int TIME_BITS_DEF     = 16;

    localparam int INTERVAL_BITS = 16;
    localparam int RATE_BITS     = 8;
    localparam int THRESH_BITS   = 10;
    localparam int CFG_W         = 14;
    localparam int CFG_IDX_W     = 2;

    localparam logic [9:0]  SEED_RST     = 10'd512;
    localparam logic [3:0]  PERIOD_RST   = 4'd2;
    localparam logic [11:0] REFRACT_RST  = 12'd250;
    localparam logic [13:0] TIMEOUT_RST  = 14'd2500;
    localparam int          INTERVAL_INIT = 600;
    localparam int          GUARD_DIV     = 5;
    localparam int          GUARD_MUL     = 3;
    localparam logic [INTERVAL_BITS-1:0] INTERVAL_RST = INTERVAL_BITS'(INTERVAL_INIT);
    localparam logic [INTERVAL_BITS-1:0] GUARD_RST =
        INTERVAL_BITS'((INTERVAL_INIT / GUARD_DIV) * GUARD_MUL);
    localparam int          RATE_NUM = 60000;
    localparam logic [RATE_BITS-1:0] RATE_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEED    = 2'd0,
        CFG_PERIOD  = 2'd1,
        CFG_REFRACT = 2'd2,
        CFG_TIMEOUT = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [9:0]  seed;
        logic [3:0]  period;
        logic [11:0] refract;
        logic [13:0] timeout;
    } cfg_t;

    // The last member sits in the lowest bits.
    typedef struct packed {
        logic [THRESH_BITS-1:0]   threshold;
        logic [INTERVAL_BITS-1:0] interval;
        logic                     pulse;
        logic                     beat;
        logic [RATE_BITS-1:0]     bpm;
    } result_t;

    localparam int RESULT_BITS = $bits(result_t);
    localparam int OUT_W       = ((RESULT_BITS + 7) / 8) * 8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SUM,
        ST_AVG_GO,
        ST_AVG,
        ST_RATE_GO,
        ST_RATE,
        ST_GUARD_GO,
        ST_GUARD,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        HIST_HOLD,
        HIST_FILL,
        HIST_SHIFT,
        HIST_ROTATE
    } hist_op_t;

endpackage

`default_nettype wire

@@ sv/pbrd_divider.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on pbrd_pkg for the divisor width.
`timescale 1ns / 1ps
`default_nettype none

module pbrd_divider #(
    parameter int DIV_BITS = 20
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [DIV_BITS-1:0]                 dividend,
    input  wire logic [pbrd_pkg::INTERVAL_BITS-1:0]  divisor,
    output logic                                     done,
    output logic [DIV_BITS-1:0]                      quotient
);
    import pbrd_pkg::*;

    localparam int CNT_BITS = $clog2(DIV_BITS + 1);

    logic [INTERVAL_BITS-1:0] rem_reg;
    logic [INTERVAL_BITS-1:0] dsr_reg;
    logic [DIV_BITS-1:0]      quo_reg;
    logic [CNT_BITS-1:0]      cnt_reg;
    logic                     run_reg;
    logic                     done_reg;

    logic [INTERVAL_BITS:0] trial;
    logic [INTERVAL_BITS:0] diff;
    logic                   fits;

    assign trial = {rem_reg, quo_reg[DIV_BITS-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == CNT_BITS'(1));
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_BITS'(DIV_BITS);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(1))
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (run_reg)
        begin
            if (fits)
            begin
                rem_reg <= diff[INTERVAL_BITS-1:0];
                quo_reg <= {quo_reg[DIV_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[INTERVAL_BITS-1:0];
                quo_reg <= {quo_reg[DIV_BITS-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

@@ sv/pbrd_history.sv @@
// Interval history as a shift register that is summed by rotating it once
// through an accumulator. Depends on pbrd_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

module pbrd_history #(
    parameter int HISTORY_DEPTH = 10,
    parameter int SUM_BITS      = 20
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire pbrd_pkg::hist_op_t                  op,
    input  wire logic [pbrd_pkg::INTERVAL_BITS-1:0]  value,
    output logic [SUM_BITS-1:0]                      sum
);
    import pbrd_pkg::*;

    logic [INTERVAL_BITS-1:0] ent_reg [HISTORY_DEPTH];
    logic [SUM_BITS-1:0]      acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                ent_reg[i] <= '0;
            end
            acc_reg <= '0;
        end
        else
        begin
            unique case (op)
                HIST_FILL:
                begin
                    for (int i = 0; i < HISTORY_DEPTH; i++)
                    begin
                        ent_reg[i] <= value;
                    end
                    acc_reg <= '0;
                end
                HIST_SHIFT:
                begin
                    for (int i = 0; i < HISTORY_DEPTH - 1; i++)
                    begin
                        ent_reg[i] <= ent_reg[i+1];
                    end
                    ent_reg[HISTORY_DEPTH-1] <= value;
                    acc_reg <= '0;
                end
                HIST_ROTATE:
                begin
                    for (int i = 0; i < HISTORY_DEPTH - 1; i++)
                    begin
                        ent_reg[i] <= ent_reg[i+1];
                    end
                    ent_reg[HISTORY_DEPTH-1] <= ent_reg[0];
                    acc_reg <= acc_reg + SUM_BITS'(ent_reg[0]);
                end
                default:
                begin
                end
            endcase
        end
    end

    assign sum = acc_reg;

endmodule

`default_nettype wire

@@ sv/pbrd_core.sv @@
// Beat detection sequencer: peak, trough and threshold tracking, beat test,
// and the steps that drive the history and the shared divider.
// Depends on pbrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pbrd_core #(
    parameter int HISTORY_DEPTH = 10,
    parameter int SAMPLE_BITS   = 10,
    parameter int TIME_BITS     = 16,
    parameter int SUM_BITS      = 20
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [SAMPLE_BITS-1:0]              sample,
    input  wire pbrd_pkg::cfg_t                      cfg,
    output logic                                     res_valid,
    input  wire logic                                res_ready,
    output pbrd_pkg::result_t                        result,
    output pbrd_pkg::hist_op_t                       hist_op,
    output logic [pbrd_pkg::INTERVAL_BITS-1:0]       hist_value,
    input  wire logic [SUM_BITS-1:0]                 hist_sum,
    output logic                                     div_start,
    output logic [SUM_BITS-1:0]                      div_dividend,
    output logic [pbrd_pkg::INTERVAL_BITS-1:0]       div_divisor,
    input  wire logic                                div_done,
    input  wire logic [SUM_BITS-1:0]                 div_quotient
);
    import pbrd_pkg::*;

    localparam int LEVEL_BITS = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;
    localparam int CNT_BITS   = $clog2(HISTORY_DEPTH);

    state_t state_reg;
    state_t state_next;

    logic [LEVEL_BITS-1:0]    sample_reg;
    logic [LEVEL_BITS-1:0]    peak_reg;
    logic [LEVEL_BITS-1:0]    trough_reg;
    logic [LEVEL_BITS-1:0]    detect_reg;
    logic [TIME_BITS-1:0]     time_reg;
    logic [TIME_BITS-1:0]     last_reg;
    logic [INTERVAL_BITS-1:0] interval_reg;
    logic [INTERVAL_BITS-1:0] guard_reg;
    logic [RATE_BITS-1:0]     rate_reg;
    logic                     first_reg;
    logic                     second_reg;
    logic                     pulse_reg;
    logic                     beat_reg;
    logic [CNT_BITS-1:0]      cnt_reg;

    logic [TIME_BITS-1:0]  elapsed;
    logic                  after_guard;
    logic                  s_below;
    logic                  s_above;
    logic                  beat;
    logic                  pulse_end;
    logic                  timed_out;
    logic [LEVEL_BITS-1:0] peak_new;
    logic [LEVEL_BITS-1:0] trough_new;
    logic [LEVEL_BITS:0]   mid_sum;
    logic [LEVEL_BITS-1:0] mid;
    logic [LEVEL_BITS-1:0] seed_ext;
    logic                  sum_last;
    logic [RATE_BITS-1:0]  rate_sat;
    logic [INTERVAL_BITS-1:0] guard_q;
    logic [INTERVAL_BITS-1:0] guard_new;

    assign elapsed     = time_reg - last_reg;
    assign after_guard = elapsed > TIME_BITS'(guard_reg);
    assign s_below     = sample_reg < detect_reg;
    assign s_above     = sample_reg > detect_reg;
    assign beat        = (elapsed > TIME_BITS'(cfg.refract)) && s_above && !pulse_reg
                         && after_guard;
    assign trough_new  = (s_below && after_guard && (sample_reg < trough_reg)) ?
                         sample_reg : trough_reg;
    assign peak_new    = (s_above && (sample_reg > peak_reg)) ? sample_reg : peak_reg;
    assign pulse_end   = s_below && pulse_reg;
    assign timed_out   = (elapsed > TIME_BITS'(cfg.timeout)) && !(beat && first_reg);

    // A rounding bit when the peak sits below the trough keeps the midpoint
    // truncated toward the trough in both orders.
    assign mid_sum  = {1'b0, peak_new} + {1'b0, trough_new}
                      + (LEVEL_BITS + 1)'(peak_new < trough_new);
    assign mid      = mid_sum[LEVEL_BITS:1];
    assign seed_ext = LEVEL_BITS'(cfg.seed);

    assign sum_last  = cnt_reg == CNT_BITS'(HISTORY_DEPTH - 1);
    assign rate_sat  = (|div_quotient[SUM_BITS-1:RATE_BITS]) ? RATE_MAX
                       : div_quotient[RATE_BITS-1:0];
    assign guard_q   = div_quotient[INTERVAL_BITS-1:0];
    assign guard_new = guard_q + {guard_q[INTERVAL_BITS-2:0], 1'b0};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (beat)
                begin
                    state_next = first_reg ? ST_GUARD_GO : ST_SUM;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_SUM:
            begin
                if (sum_last)
                begin
                    state_next = ST_AVG_GO;
                end
            end
            ST_AVG_GO:
            begin
                state_next = ST_AVG;
            end
            ST_AVG:
            begin
                if (div_done)
                begin
                    state_next = ST_RATE_GO;
                end
            end
            ST_RATE_GO:
            begin
                state_next = ST_RATE;
            end
            ST_RATE:
            begin
                if (div_done)
                begin
                    state_next = ST_GUARD_GO;
                end
            end
            ST_GUARD_GO:
            begin
                state_next = ST_GUARD;
            end
            ST_GUARD:
            begin
                if (div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        res_valid    = 1'b0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        hist_op      = HIST_HOLD;
        hist_value   = elapsed[INTERVAL_BITS-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_EVAL:
            begin
                if (beat && !first_reg)
                begin
                    hist_op = second_reg ? HIST_FILL : HIST_SHIFT;
                end
            end
            ST_SUM:
            begin
                hist_op = HIST_ROTATE;
            end
            ST_AVG_GO:
            begin
                div_start    = 1'b1;
                div_dividend = hist_sum;
                div_divisor  = INTERVAL_BITS'(HISTORY_DEPTH);
            end
            ST_RATE_GO:
            begin
                div_start    = 1'b1;
                div_dividend = SUM_BITS'(RATE_NUM);
                div_divisor  = div_quotient[INTERVAL_BITS-1:0];
            end
            ST_GUARD_GO:
            begin
                div_start    = 1'b1;
                div_dividend = SUM_BITS'(interval_reg);
                div_divisor  = INTERVAL_BITS'(GUARD_DIV);
            end
            ST_EMIT:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            peak_reg     <= LEVEL_BITS'(SEED_RST);
            trough_reg   <= LEVEL_BITS'(SEED_RST);
            detect_reg   <= LEVEL_BITS'(SEED_RST);
            time_reg     <= '0;
            last_reg     <= '0;
            interval_reg <= INTERVAL_RST;
            guard_reg    <= GUARD_RST;
            rate_reg     <= '0;
            first_reg    <= 1'b1;
            second_reg   <= 1'b0;
            pulse_reg    <= 1'b0;
            beat_reg     <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && in_valid)
            begin
                time_reg <= time_reg + TIME_BITS'(cfg.period);
            end
            if (state_reg == ST_EVAL)
            begin
                peak_reg   <= peak_new;
                trough_reg <= trough_new;
                beat_reg   <= beat;
                cnt_reg    <= '0;
                if (beat)
                begin
                    pulse_reg    <= 1'b1;
                    interval_reg <= elapsed[INTERVAL_BITS-1:0];
                    last_reg     <= time_reg;
                    second_reg   <= first_reg;
                    first_reg    <= 1'b0;
                end
                if (pulse_end)
                begin
                    pulse_reg  <= 1'b0;
                    detect_reg <= mid;
                    peak_reg   <= mid;
                    trough_reg <= mid;
                end
                if (timed_out)
                begin
                    detect_reg <= seed_ext;
                    peak_reg   <= seed_ext;
                    trough_reg <= seed_ext;
                    last_reg   <= time_reg;
                    first_reg  <= 1'b1;
                    second_reg <= 1'b0;
                end
            end
            if (state_reg == ST_SUM)
            begin
                cnt_reg <= cnt_reg + CNT_BITS'(1);
            end
            if (state_reg == ST_RATE && div_done)
            begin
                rate_reg <= rate_sat;
            end
            if (state_reg == ST_GUARD && div_done)
            begin
                guard_reg <= guard_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            sample_reg <= LEVEL_BITS'(sample);
        end
    end

    assign result.threshold = detect_reg[THRESH_BITS-1:0];
    assign result.interval  = interval_reg;
    assign result.pulse     = pulse_reg;
    assign result.beat      = beat_reg;
    assign result.bpm       = rate_reg;

endmodule

`default_nettype wire

@@ sv/pulse_beat_rate_detector_top.sv @@
// Top level of the pulse beat rate detector: configuration registers, output
// register and the core, history and divider. Depends on pbrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

// One sample is accepted at a time and gives exactly one result transaction.
// A sample without a beat passes through the evaluate and emit states to the
// output register, and the next sample can be taken once the core is back in
// idle. The first beat after a restart also updates the beat guard through the
// bit-serial divider, whose width DIV_BITS is 16 + clog2(HISTORY_DEPTH) (20 by
// default). Every later beat rotates the interval history once through an
// accumulator and then runs three divisions one bit per cycle (average, rate,
// guard). A new sample is accepted while the previous result still waits in
// the output register; a finished result waits in the core while that
// register is full and not being read.
module pulse_beat_rate_detector_top #(
    parameter int HISTORY_DEPTH = pbrd_pkg::HISTORY_DEPTH_DEF,
    parameter int SAMPLE_BITS   = pbrd_pkg::SAMPLE_BITS_DEF,
    parameter int TIME_BITS     = pbrd_pkg::TIME_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // sample, zero padded to whole bytes
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // bpm, beat_found, pulse_active, interval_ms, threshold_level, zero padding
    output logic [pbrd_pkg::OUT_W-1:0]               m_axis_tdata,
    input  wire logic                                cfg_we,
    input  wire logic [pbrd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pbrd_pkg::CFG_W-1:0]          cfg_data
);
    import pbrd_pkg::*;

    localparam int SUM_BITS = INTERVAL_BITS + $clog2(HISTORY_DEPTH);

    cfg_t    cfg_reg;
    result_t out_reg;
    logic    out_valid_reg;

    logic                     res_valid;
    logic                     res_ready;
    result_t                  result;
    hist_op_t                 hist_op;
    logic [INTERVAL_BITS-1:0] hist_value;
    logic [SUM_BITS-1:0]      hist_sum;
    logic                     div_start;
    logic [SUM_BITS-1:0]      div_dividend;
    logic [INTERVAL_BITS-1:0] div_divisor;
    logic                     div_done;
    logic [SUM_BITS-1:0]      div_quotient;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.seed    <= SEED_RST;
            cfg_reg.period  <= PERIOD_RST;
            cfg_reg.refract <= REFRACT_RST;
            cfg_reg.timeout <= TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SEED:    cfg_reg.seed    <= cfg_data[9:0];
                CFG_PERIOD:  cfg_reg.period  <= cfg_data[3:0];
                CFG_REFRACT: cfg_reg.refract <= cfg_data[11:0];
                CFG_TIMEOUT: cfg_reg.timeout <= cfg_data[13:0];
                default:
                begin
                end
            endcase
        end
    end

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= result;
        end
    end

    pbrd_core #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .TIME_BITS     (TIME_BITS),
        .SUM_BITS      (SUM_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .sample       (s_axis_tdata[SAMPLE_BITS-1:0]),
        .cfg          (cfg_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .result       (result),
        .hist_op      (hist_op),
        .hist_value   (hist_value),
        .hist_sum     (hist_sum),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_done     (div_done),
        .div_quotient (div_quotient)
    );

    pbrd_history #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .SUM_BITS      (SUM_BITS)
    ) u_history (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (hist_op),
        .value (hist_value),
        .sum   (hist_sum)
    );

    pbrd_divider #(
        .DIV_BITS (SUM_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(out_reg);

endmodule

`default_nettype wire

@@ sv/pbrd_checker.sv @@
// Port-level checks for the pulse beat rate detector, bound to the top level.
// Depends on pbrd_pkg for the result layout.
`timescale 1ns / 1ps
`default_nettype none

module pbrd_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        s_axis_tvalid,
    input wire logic                        s_axis_tready,
    input wire logic                        m_axis_tvalid,
    input wire logic                        m_axis_tready,
    input wire logic [pbrd_pkg::OUT_W-1:0]  m_axis_tdata
);
    import pbrd_pkg::*;

    logic       in_acc;
    logic       out_acc;
    logic [1:0] pend_reg;
    result_t    res;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign res     = result_t'(m_axis_tdata[RESULT_BITS-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + 2'(in_acc) - 2'(out_acc);
        end
    end

    // Every result belongs to a sample that was taken and not yet answered.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> pend_reg != 2'd0)
        else $error("result shown with no sample outstanding");

    // At most one sample in work and one result waiting.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> pend_reg != 2'd2)
        else $error("sample taken while two are outstanding");

    a_beat_in_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.beat |-> res.pulse)
        else $error("beat reported without an active pulse");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind pulse_beat_rate_detector_top pbrd_checker u_pbrd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
